FILE: hdl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants for the smoothed central derivative
// Sample and result widths, register map, coefficient and scale tables.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int SAMPLE_BITS         = 16;
  localparam int MAX_HALF_LENGTH_DEF = 5;
  localparam int OUT_W               = 32;
  localparam int GAIN_W              = 32;
  localparam int SEL_W               = 2;

  // Largest coefficient sum is 126, so the weighted sum needs 8 bits of growth
  localparam int SUM_W  = SAMPLE_BITS + 8;
  localparam int MAG_W  = SUM_W - 1;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int SH_W   = 5;

  // APB register map, one 32-bit word per register
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH_SELECT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_INV_STEP_GAIN = 1'b1;

  localparam logic [SEL_W-1:0]  LENGTH_SELECT_RST = 2'd3;
  localparam logic [GAIN_W-1:0] INV_STEP_GAIN_RST = 32'd65536;

  // Holoborodko coefficients, sel = half length - 2, k = tap offset
  function automatic logic [6:0] coef_f(input int sel, input int k);
    logic [6:0] c;
    c = '0;
    unique case (sel)
      0: begin
        if (k == 1) c = 7'd2;
        else if (k == 2) c = 7'd1;
      end
      1: begin
        if (k == 1) c = 7'd5;
        else if (k == 2) c = 7'd4;
        else if (k == 3) c = 7'd1;
      end
      2: begin
        if (k == 1) c = 7'd14;
        else if (k == 2) c = 7'd14;
        else if (k == 3) c = 7'd6;
        else if (k == 4) c = 7'd1;
      end
      default: begin
        if (k == 1) c = 7'd42;
        else if (k == 2) c = 7'd48;
        else if (k == 3) c = 7'd27;
        else if (k == 4) c = 7'd8;
        else if (k == 5) c = 7'd1;
      end
    endcase
    return c;
  endfunction

  // Total right shift: 16 fraction bits of the gain plus log2 of the denominator
  function automatic logic [SH_W-1:0] out_shift_f(input logic [SEL_W-1:0] sel);
    return SH_W'(19) + {sel, 1'b0};
  endfunction

endpackage

FILE: hdl/smooth_central_derivative_top.sv
// ----------------------------------------------------------------------------
// smooth_central_derivative_top: streaming smoothed first derivative
// Holoborodko noise-robust differentiator, 5 to 11 taps, Q16.16 step gain,
// rounded and saturated to 32 bits, with end-of-stream flush.
// ----------------------------------------------------------------------------
//   channel   | handshake                    | payload
//   ----------+------------------------------+-------------------------------
//   input     | in_valid_i / in_stall_o      | sample_i, last_i
//   output    | out_valid_o / out_stall_i    | derivative_o, last_out_o
//   config    | APB psel/penable/pwrite      | paddr, pwdata, prdata
//
// One sample per cycle while in_stall_o is low. The edge that accepts a
// sample loads the window; the result it causes then moves through the sum
// and scale registers. A sample marked last starts a flush that repeats the
// newest sample into the window M times (M = half length); input stalls
// until the flush is done. Each stage holds under an output stall and
// bubbles are squeezed out. Reset clears control state only.
module smooth_central_derivative_top #(
  parameter int MAX_HALF_LENGTH = scd_pkg::MAX_HALF_LENGTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   last_i,
  // output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [scd_pkg::OUT_W-1:0]       derivative_o,
  output logic                                   last_out_o,
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [scd_pkg::APB_AW-1:0]             paddr,
  input  logic [scd_pkg::APB_DW-1:0]             pwdata,
  output logic [scd_pkg::APB_DW-1:0]             prdata,
  output logic                                   pready
);
  import scd_pkg::*;

  localparam int DEPTH = 2 * MAX_HALF_LENGTH + 1;
  localparam int NSEL  = MAX_HALF_LENGTH - 1;
  localparam int POS_W = $clog2(MAX_HALF_LENGTH + 1);
  localparam logic [SEL_W-1:0] SEL_MAX = SEL_W'(MAX_HALF_LENGTH - 2);
  localparam logic [POS_W-1:0] FILL_MAX = POS_W'(MAX_HALF_LENGTH);

  // -------------------------------------------------------------- config
  logic [SEL_W-1:0]     length_select_q;
  logic [GAIN_W-1:0]    inv_step_gain_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_select_q <= LENGTH_SELECT_RST;
      inv_step_gain_q <= INV_STEP_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LENGTH_SELECT: length_select_q <= pwdata[SEL_W-1:0];
        REG_INV_STEP_GAIN: inv_step_gain_q <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LENGTH_SELECT: prdata = APB_DW'(length_select_q);
      REG_INV_STEP_GAIN: prdata = APB_DW'(inv_step_gain_q);
      default:           prdata = '0;
    endcase
  end

  logic [SEL_W-1:0] sel;
  logic [POS_W-1:0] half_len;

  assign sel      = (length_select_q > SEL_MAX) ? SEL_MAX : length_select_q;
  assign half_len = POS_W'(sel) + POS_W'(2);

  // -------------------------------------------------------------- handshake
  logic o_ld, s_ld, j_adv, in_accept;

  logic                  job_vld_q, job_vld_d;
  logic                  job_last_q, job_last_d;
  logic                  sum_vld_q;
  logic                  out_valid_q;

  assign o_ld      = !out_valid_q || !out_stall_i;
  assign s_ld      = !sum_vld_q || o_ld;
  assign j_adv     = !job_vld_q || s_ld;

  // -------------------------------------------------------------- window stage
  logic signed [SAMPLE_BITS-1:0] win_q [DEPTH];
  logic signed [SAMPLE_BITS-1:0] win_d [DEPTH];
  logic                          win_en;
  logic [POS_W-1:0] fill_q, fill_d;
  logic             start_q, start_d;
  logic             fl_q, fl_d;          // flush shifts still to do
  logic [POS_W-1:0] fl_cnt_q, fl_cnt_d;  // equals the centre position
  logic [POS_W-1:0] pend_q, pend_d;
  logic [POS_W-1:0] seen, pend, cnt_nxt;

  assign in_stall_o = fl_q || (job_vld_q && !s_ld);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    win_d      = win_q;
    win_en     = 1'b0;
    fill_d     = fill_q;
    start_d    = start_q;
    fl_d       = fl_q;
    fl_cnt_d   = fl_cnt_q;
    pend_d     = pend_q;
    job_vld_d  = job_vld_q;
    job_last_d = job_last_q;
    seen       = start_q ? '0 : fill_q;
    pend       = (seen < half_len) ? seen : half_len;
    cnt_nxt    = fl_cnt_q - POS_W'(1);

    if (fl_q && j_adv) begin
      // Replicating the newest sample moves the next centre into tap M
      win_en = 1'b1;
      for (int j = DEPTH - 1; j > 0; j--) win_d[j] = win_q[j-1];
      fl_cnt_d   = cnt_nxt;
      fl_d       = (cnt_nxt != '0);
      job_vld_d  = (cnt_nxt <= pend_q);
      job_last_d = (cnt_nxt == '0);
    end else if (in_accept) begin
      win_en = 1'b1;
      if (start_q) begin
        for (int j = 0; j < DEPTH; j++) win_d[j] = sample_i;
      end else begin
        for (int j = DEPTH - 1; j > 0; j--) win_d[j] = win_q[j-1];
        win_d[0] = sample_i;
      end
      job_last_d = 1'b0;
      if (last_i) begin
        start_d   = 1'b1;
        fill_d    = '0;
        fl_d      = 1'b1;
        fl_cnt_d  = half_len;
        pend_d    = pend;
        job_vld_d = (pend == half_len);
      end else begin
        start_d   = 1'b0;
        job_vld_d = (seen >= half_len);
        fill_d    = (seen < FILL_MAX) ? seen + POS_W'(1) : seen;
      end
    end else if (j_adv) begin
      job_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      start_q    <= 1'b1;
      fl_q       <= 1'b0;
      fl_cnt_q   <= '0;
      pend_q     <= '0;
      job_vld_q  <= 1'b0;
      job_last_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      start_q    <= start_d;
      fl_q       <= fl_d;
      fl_cnt_q   <= fl_cnt_d;
      pend_q     <= pend_d;
      job_vld_q  <= job_vld_d;
      job_last_q <= job_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_en) win_q <= win_d;
  end

  // -------------------------------------------------------------- sum stage
  logic signed [SUM_W-1:0] term [1:MAX_HALF_LENGTH];
  logic signed [SUM_W-1:0] sum;
  logic                    sum_neg;
  logic [MAG_W-1:0]        sum_mag;
  logic [MAG_W-1:0]        mag_q;
  logic                    neg_q;
  logic                    sum_last_q;

  // Centre sits at tap M; the clamp on the index only guards unused arms
  always_comb begin
    int a, b;
    logic signed [SAMPLE_BITS:0] diff;
    a    = 0;
    b    = 0;
    diff = '0;
    sum  = '0;
    for (int k = 1; k <= MAX_HALF_LENGTH; k++) begin
      term[k] = '0;
      for (int s = 0; s < NSEL; s++) begin
        a = (s + 2 >= k) ? s + 2 - k : 0;
        b = s + 2 + k;
        if (sel == SEL_W'(s) && k <= s + 2) begin
          diff    = {win_q[a][SAMPLE_BITS-1], win_q[a]} -
                    {win_q[b][SAMPLE_BITS-1], win_q[b]};
          term[k] = SUM_W'(diff) * $signed(SUM_W'(coef_f(s, k)));
        end
      end
      sum = sum + term[k];
    end
  end

  assign sum_neg = sum[SUM_W-1];
  assign sum_mag = sum_neg ? MAG_W'(-sum) : MAG_W'(sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sum_vld_q <= 1'b0;
    else if (s_ld) sum_vld_q <= job_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (s_ld && job_vld_q) begin
      mag_q      <= sum_mag;
      neg_q      <= sum_neg;
      sum_last_q <= job_last_q;
    end
  end

  // -------------------------------------------------------------- scale stage
  logic [PROD_W-1:0]       prod, rnd, quo;
  logic [SH_W-1:0]         sh;
  logic signed [OUT_W-1:0] res;
  logic signed [OUT_W-1:0] derivative_q;
  logic                    last_out_q;

  // Round half away from zero on the magnitude, then restore the sign
  always_comb begin
    sh   = out_shift_f(sel);
    prod = PROD_W'(mag_q) * PROD_W'(inv_step_gain_q);
    rnd  = prod + (PROD_W'(1) << (sh - SH_W'(1)));
    quo  = rnd >> sh;
    if (neg_q) begin
      if (quo > PROD_W'(33'h0_8000_0000)) res = {1'b1, {(OUT_W-1){1'b0}}};
      else                                 res = -$signed(quo[OUT_W-1:0]);
    end else begin
      if (quo > PROD_W'(32'h7FFF_FFFF)) res = {1'b0, {(OUT_W-1){1'b1}}};
      else                               res = $signed(quo[OUT_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (o_ld) out_valid_q <= sum_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (o_ld && sum_vld_q) begin
      derivative_q <= res;
      last_out_q   <= sum_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign derivative_o = derivative_q;
  assign last_out_o   = last_out_q;

endmodule

FILE: tb/scd_slope_checker.sv
// ----------------------------------------------------------------------------
// scd_slope_checker: scoreboard for the smoothed central derivative
// Mirrors register writes and accepted sample beats, predicts the derivative
// beats they cause, and compares every output beat in order.
// ----------------------------------------------------------------------------
module scd_slope_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_stall_i,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   last_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_stall_i,
  input  logic signed [scd_pkg::OUT_W-1:0]       derivative_i,
  input  logic                                   last_out_i,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic                                   pready,
  input  logic [scd_pkg::APB_AW-1:0]             paddr,
  input  logic [scd_pkg::APB_DW-1:0]             pwdata,
  output int                                     fail_count_o,
  output int                                     pending_o,
  output int                                     checked_o,
  output int                                     full_scale_o
);
  import scd_pkg::*;

  localparam int HIST_DEPTH = 2 * MAX_HALF_LENGTH_DEF + 1;

  typedef struct packed {
    logic signed [OUT_W-1:0] derivative;
    logic                    last_out;
  } slope_beat_t;

  logic [SEL_W-1:0]               length_sel;
  logic [GAIN_W-1:0]              step_gain;
  logic signed [SAMPLE_BITS-1:0]  hist [HIST_DEPTH];  // newest at 0
  int                             fill;
  bit                             fresh;
  slope_beat_t                    expected_slopes [$];

  function automatic int tap_weight(int sel, int k);
    logic [39:0] row;
    case (sel)
      0:       row = {8'd0, 8'd0, 8'd0, 8'd1, 8'd2};
      1:       row = {8'd0, 8'd0, 8'd1, 8'd4, 8'd5};
      2:       row = {8'd0, 8'd1, 8'd6, 8'd14, 8'd14};
      default: row = {8'd1, 8'd8, 8'd27, 8'd48, 8'd42};
    endcase
    return int'(row[8*(k-1) +: 8]);
  endfunction

  // Centre at history position pos; neighbors clamp to the window ends
  function automatic logic signed [OUT_W-1:0] slope_at(int pos, int sel, int m);
    longint            acc;
    longint unsigned   mag, lo, hi, q;
    int                k, fwd, bwd, shift;
    bit                neg;
    acc = 0;
    for (k = 1; k <= m; k++) begin
      fwd = (pos >= k) ? pos - k : 0;
      bwd = (pos + k >= HIST_DEPTH) ? HIST_DEPTH - 1 : pos + k;
      acc += longint'(tap_weight(sel, k)) * (longint'(hist[fwd]) - longint'(hist[bwd]));
    end
    neg   = acc < 0;
    mag   = neg ? longint'(-acc) : longint'(acc);
    shift = 3 + 2 * sel;
    lo    = mag * longint'(step_gain[15:0]) + (64'd1 << (15 + shift));
    hi    = mag * longint'(step_gain[31:16]);
    q     = (hi + (lo >> 16)) >> shift;
    if (neg)
      return (q > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
  endfunction

  function automatic void push_slope(logic signed [OUT_W-1:0] d, logic l);
    slope_beat_t b;
    b.derivative = d;
    b.last_out   = l;
    expected_slopes.push_back(b);
    if (d == 32'sh7FFF_FFFF || d == 32'sh8000_0000) full_scale_o++;
  endfunction

  task automatic take_sample(logic signed [SAMPLE_BITS-1:0] x, logic is_last);
    int sel, m, j, p;
    sel = int'(length_sel);
    m   = sel + 2;
    if (fresh) begin
      for (j = 0; j < HIST_DEPTH; j++) hist[j] = x;
      fresh = 0;
      fill  = 0;
    end else begin
      for (j = HIST_DEPTH - 1; j > 0; j--) hist[j] = hist[j-1];
      hist[0] = x;
    end
    if (!is_last) begin
      if (fill >= m) push_slope(slope_at(m, sel, m), 1'b0);
      if (fill < MAX_HALF_LENGTH_DEF) fill++;
    end else begin
      // flush every pending centre, oldest first
      for (p = (fill < m) ? fill : m; p >= 0; p--)
        push_slope(slope_at(p, sel, m), p == 0);
      fresh = 1;
      fill  = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_sel = LENGTH_SELECT_RST;
      step_gain  = INV_STEP_GAIN_RST;
      for (int j = 0; j < HIST_DEPTH; j++) hist[j] = '0;
      fill  = 0;
      fresh = 1;
      expected_slopes.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      full_scale_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_AW-1:2] == REG_LENGTH_SELECT) length_sel = pwdata[SEL_W-1:0];
        else if (paddr[APB_AW-1:2] == REG_INV_STEP_GAIN) step_gain = pwdata[GAIN_W-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_slopes.size() == 0) begin
          $error("derivative beat with nothing expected: derivative %0d last_out %0b",
                 derivative_i, last_out_i);
          fail_count_o++;
        end else begin
          slope_beat_t want;
          want = expected_slopes.pop_front();
          checked_o++;
          if (derivative_i !== want.derivative) begin
            $error("derivative mismatch: expected %0d, actual %0d",
                   want.derivative, derivative_i);
            fail_count_o++;
          end
          if (last_out_i !== want.last_out) begin
            $error("last_out mismatch: expected %0b, actual %0b", want.last_out, last_out_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_sample(sample_i, last_i);
      pending_o = expected_slopes.size();
    end
  end

endmodule

FILE: tb/smooth_central_derivative_top_test.sv
// ----------------------------------------------------------------------------
// smooth_central_derivative_top_test: stimulus and verdict for the derivative
// Directed streams for full-scale inputs, gain extremes, short and
// single-sample streams and a mid-stream length change, then random streams
// under random settings with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module smooth_central_derivative_top_test;
  import scd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int BEAT_TARGET  = 400;
  localparam int SETTLE_TICKS = 8;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i    = '0;
  logic                          last_i      = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [OUT_W-1:0]       derivative_o;
  logic                          last_out_o;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [APB_AW-1:0]             paddr       = '0;
  logic [APB_DW-1:0]             pwdata      = '0;
  logic [APB_DW-1:0]             prdata;
  logic                          pready;

  int fail_count, pending, checked, full_scale;
  int cycle_count = 0;
  int beats_sent  = 0;
  int streams     = 0;
  int reg_writes  = 0;
  bit tx_burst    = 1'b0;
  bit rx_burst    = 1'b0;
  int prev_sample = 0;
  int rx_wait     = 0;

  smooth_central_derivative_top u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .sample_i, .last_i,
    .out_valid_o, .out_stall_i, .derivative_o, .last_out_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  scd_slope_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .sample_i, .last_i,
    .out_valid_i(out_valid_o), .out_stall_i, .derivative_i(derivative_o),
    .last_out_i(last_out_o),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .full_scale_o(full_scale)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap(bit burst);
    if (burst || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // sink: a fresh, possibly empty, stall run after every accepted derivative beat
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) rx_wait = pick_gap(rx_burst);
      @(negedge clk_i);
      if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] s, input logic l);
    int gap;
    gap = pick_gap(tx_burst);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
    prev_sample = int'(s);
  endtask

  // wait until every predicted beat is out and the pipeline is quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
    int t;
    case ($urandom_range(0, 9))
      0: t = $urandom_range(0, 1) ? 32767 : -32768;
      1, 2, 3: begin
        t = prev_sample + $urandom_range(0, 512) - 256;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
      end
      default: t = int'($signed(16'($urandom)));
    endcase
    return SAMPLE_BITS'(t);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0001_0000;
      3:       return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_stream(input int len);
    int cut, i;
    cut = -1;
    if (len >= 3 && $urandom_range(0, 7) == 0) cut = $urandom_range(1, len - 2);
    for (i = 0; i < len; i++) begin
      if (i == cut) begin
        settle();
        apb_write(REG_LENGTH_SELECT, $urandom_range(0, 3));
      end
      send_beat(next_sample(), i == len - 1);
    end
    streams++;
  endtask

  initial begin
    int n, s;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-sample stream at reset settings: one zero result
    send_beat(16'sh7FFF, 1'b1);
    // full-scale alternation through 11 taps
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh7FFF, 1'b0);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh7FFF, 1'b0);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh7FFF, 1'b0);
    send_beat(16'sd0, 1'b1);
    settle();
    apb_write(REG_INV_STEP_GAIN, 32'hFFFF_FFFF);
    // step up then down at max gain: saturates both ways
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh7FFF, 1'b0);
    send_beat(16'sh7FFF, 1'b0);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh8000, 1'b1);
    // short stream, fewer samples than the half length
    send_beat(16'sd100, 1'b0);
    send_beat(-16'sd200, 1'b0);
    send_beat(16'sd300, 1'b1);
    settle();
    apb_write(REG_LENGTH_SELECT, 32'd0);
    apb_write(REG_INV_STEP_GAIN, 32'h0);
    send_beat(16'sd1234, 1'b0);
    send_beat(-16'sd4321, 1'b1);
    settle();
    apb_write(REG_INV_STEP_GAIN, 32'h0001_0000);
    // half length grows from 2 to 5 partway through a stream
    send_beat(16'sd5, 1'b0);
    send_beat(16'sd10, 1'b0);
    send_beat(16'sd20, 1'b0);
    settle();
    apb_write(REG_LENGTH_SELECT, 32'd3);
    send_beat(16'sd40, 1'b0);
    send_beat(16'sd80, 1'b0);
    send_beat(16'sd160, 1'b1);
    streams += 6;

    while (beats_sent < BEAT_TARGET) begin
      settle();
      apb_write(REG_LENGTH_SELECT, $urandom_range(0, 3));
      apb_write(REG_INV_STEP_GAIN, pick_gain());
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 4);
      for (s = 0; s < n; s++)
        run_stream(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12));
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d sample beats in %0d streams with %0d register writes",
             beats_sent, streams, reg_writes);
    $display("checked %0d derivative beats, %0d of them at full scale", checked, full_scale);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/scd_pkg.sv
hdl/smooth_central_derivative_top.sv
tb/scd_slope_checker.sv
tb/smooth_central_derivative_top_test.sv
